@@ hdl/tlbtr_pkg.sv @@
`timescale 1ns / 1ps

package tlbtr_pkg;

   localparam int ENTRIES_DEF    = 16;
   localparam int PAGE_BYTES_DEF = 128;
   localparam int PHYS_PAGES_DEF = 32;

   localparam int VA_W     = 32;
   localparam int SIZE_W   = 2;
   localparam int TIME_W   = 32;
   localparam int PAGE_W   = 25;
   localparam int FRAME_W  = 16;
   localparam int PA_W     = 12;
   localparam int STATUS_W = 3;
   localparam int ATTR_W   = PAGE_W + FRAME_W + 3;

   localparam logic OP_TRANSLATE = 1'b0;
   localparam logic OP_REFILL    = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;
   localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd2;

   localparam logic [VA_W-1:0] ALIGN_WORD_MASK = 32'h3;
   localparam logic [VA_W-1:0] ALIGN_HALF_MASK = 32'h1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK     = 3'd0,
      STAT_ALIGN  = 3'd1,
      STAT_MISS   = 3'd2,
      STAT_RDONLY = 3'd3,
      STAT_BUS    = 3'd4
   } status_type;

   typedef struct packed {
      logic load_req;
      logic match;
      logic eval;
      logic pick;
      logic scan_rd;
      logic victim_rd;
      logic fill;
   } cmd_type;

   typedef struct packed {
      logic op_refill;
      logic any_free;
   } stat_type;

endpackage

@@ hdl/tlbtr_if.sv @@
`timescale 1ns / 1ps

interface tlbtr_req_if;
   logic                                valid;
   logic                                ready;
   logic                                opcode;
   logic [tlbtr_pkg::VA_W-1:0]          virt_addr;
   logic [tlbtr_pkg::SIZE_W-1:0]        size_code;
   logic                                is_write;
   logic [tlbtr_pkg::TIME_W-1:0]        time_stamp;
   logic [tlbtr_pkg::FRAME_W-1:0]       fill_frame;
   logic                                fill_read_only;
   logic                                fill_dirty;
   logic                                fill_use;

   modport source (
      output valid, opcode, virt_addr, size_code, is_write, time_stamp,
             fill_frame, fill_read_only, fill_dirty, fill_use,
      input  ready
   );
   modport sink (
      input  valid, opcode, virt_addr, size_code, is_write, time_stamp,
             fill_frame, fill_read_only, fill_dirty, fill_use,
      output ready
   );
endinterface

interface tlbtr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [tlbtr_pkg::STATUS_W-1:0]      status;
   logic [tlbtr_pkg::PA_W-1:0]          phys_addr;
   logic                                victim_valid;
   logic [tlbtr_pkg::PAGE_W-1:0]        victim_page;
   logic [tlbtr_pkg::FRAME_W-1:0]       victim_frame;
   logic                                victim_read_only;
   logic                                victim_dirty;
   logic                                victim_use;

   modport source (
      output valid, status, phys_addr, victim_valid, victim_page, victim_frame,
             victim_read_only, victim_dirty, victim_use,
      input  ready
   );
   modport sink (
      input  valid, status, phys_addr, victim_valid, victim_page, victim_frame,
             victim_read_only, victim_dirty, victim_use,
      output ready
   );
endinterface

@@ hdl/tlb_translate_and_refill.sv @@
`timescale 1ns / 1ps
// A translate passes through the states MATCH, EVAL and RESP; a refill into a free
// slot through PICK, VREAD, FILL and RESP; a refill with every entry valid adds a
// victim scan (SCAN, DRAIN) after PICK, with one time stamp read per cycle from the
// time store of the replacement mode. One request at a time: the next request is
// taken at the earliest in the cycle after the response is taken.
// Reset (synchronous): all entries invalid, replacement mode LRU; no clearing pass.
module tlb_translate_and_refill #(
   parameter int ENTRIES    = tlbtr_pkg::ENTRIES_DEF,
   parameter int PAGE_BYTES = tlbtr_pkg::PAGE_BYTES_DEF,
   parameter int PHYS_PAGES = tlbtr_pkg::PHYS_PAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tlbtr_req_if.sink   req_chan,
   tlbtr_rsp_if.source rsp_chan,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int IDX_W = $clog2(ENTRIES);

   tlbtr_pkg::cmd_type  cmd;
   tlbtr_pkg::stat_type stat;
   logic [IDX_W-1:0]    scan_idx;

   tlbtr_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd),
      .scan_idx  (scan_idx)
   );

   tlbtr_datapath #(
      .ENTRIES    (ENTRIES),
      .PAGE_BYTES (PAGE_BYTES),
      .PHYS_PAGES (PHYS_PAGES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .scan_idx             (scan_idx),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_opcode           (req_chan.opcode),
      .req_virt_addr        (req_chan.virt_addr),
      .req_size_code        (req_chan.size_code),
      .req_is_write         (req_chan.is_write),
      .req_time_stamp       (req_chan.time_stamp),
      .req_fill_frame       (req_chan.fill_frame),
      .req_fill_read_only   (req_chan.fill_read_only),
      .req_fill_dirty       (req_chan.fill_dirty),
      .req_fill_use         (req_chan.fill_use),
      .rsp_status           (rsp_chan.status),
      .rsp_phys_addr        (rsp_chan.phys_addr),
      .rsp_victim_valid     (rsp_chan.victim_valid),
      .rsp_victim_page      (rsp_chan.victim_page),
      .rsp_victim_frame     (rsp_chan.victim_frame),
      .rsp_victim_read_only (rsp_chan.victim_read_only),
      .rsp_victim_dirty     (rsp_chan.victim_dirty),
      .rsp_victim_use       (rsp_chan.victim_use)
   );

endmodule

@@ hdl/tlbtr_ram.sv @@
`timescale 1ns / 1ps

module tlbtr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/tlbtr_ctrl.sv @@
`timescale 1ns / 1ps

module tlbtr_ctrl #(
   parameter int ENTRIES = tlbtr_pkg::ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  tlbtr_pkg::stat_type        stat,
   output tlbtr_pkg::cmd_type         cmd,
   output logic [$clog2(ENTRIES)-1:0] scan_idx
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MATCH,
      S_EVAL,
      S_PICK,
      S_SCAN,
      S_DRAIN,
      S_VREAD,
      S_FILL,
      S_RESP
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = stat.op_refill ? S_PICK : S_MATCH;
            end
         end
         S_MATCH: begin
            cmd.match = 1'b1;
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_RESP;
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            cnt_in   = '0;
            state_in = stat.any_free ? S_VREAD : S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         // last time compare lands here
         S_DRAIN: state_in = S_VREAD;
         S_VREAD: begin
            cmd.victim_rd = 1'b1;
            state_in      = S_FILL;
         end
         S_FILL: begin
            cmd.fill = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign scan_idx = cnt_ff;

endmodule

@@ hdl/tlbtr_datapath.sv @@
`timescale 1ns / 1ps

module tlbtr_datapath #(
   parameter int ENTRIES    = tlbtr_pkg::ENTRIES_DEF,
   parameter int PAGE_BYTES = tlbtr_pkg::PAGE_BYTES_DEF,
   parameter int PHYS_PAGES = tlbtr_pkg::PHYS_PAGES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tlbtr_pkg::cmd_type                 cmd,
   output tlbtr_pkg::stat_type                stat,
   input  logic [$clog2(ENTRIES)-1:0]         scan_idx,
   input  logic                               csr_wr_en,
   input  logic                               csr_wr_data,
   input  logic                               req_opcode,
   input  logic [tlbtr_pkg::VA_W-1:0]         req_virt_addr,
   input  logic [tlbtr_pkg::SIZE_W-1:0]       req_size_code,
   input  logic                               req_is_write,
   input  logic [tlbtr_pkg::TIME_W-1:0]       req_time_stamp,
   input  logic [tlbtr_pkg::FRAME_W-1:0]      req_fill_frame,
   input  logic                               req_fill_read_only,
   input  logic                               req_fill_dirty,
   input  logic                               req_fill_use,
   output logic [tlbtr_pkg::STATUS_W-1:0]     rsp_status,
   output logic [tlbtr_pkg::PA_W-1:0]         rsp_phys_addr,
   output logic                               rsp_victim_valid,
   output logic [tlbtr_pkg::PAGE_W-1:0]       rsp_victim_page,
   output logic [tlbtr_pkg::FRAME_W-1:0]      rsp_victim_frame,
   output logic                               rsp_victim_read_only,
   output logic                               rsp_victim_dirty,
   output logic                               rsp_victim_use
);

   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int PAGE_BITS = $clog2(PAGE_BYTES);
   localparam int VA_W      = tlbtr_pkg::VA_W;
   localparam int PAGE_W    = tlbtr_pkg::PAGE_W;
   localparam int FRAME_W   = tlbtr_pkg::FRAME_W;
   localparam int TIME_W    = tlbtr_pkg::TIME_W;
   localparam int ATTR_W    = tlbtr_pkg::ATTR_W;
   localparam int PA_W      = tlbtr_pkg::PA_W;

   // captured request
   logic [VA_W-1:0]              va_ff;
   logic [tlbtr_pkg::SIZE_W-1:0] size_ff;
   logic                         wr_ff;
   logic [TIME_W-1:0]            time_ff;
   logic [FRAME_W-1:0]           fill_frame_ff;
   logic                         fill_ro_ff;
   logic                         fill_dirty_ff;
   logic                         fill_use_ff;

   logic                         mode_ff;
   logic [ENTRIES-1:0]           valid_ff;
   logic [PAGE_W-1:0]            page_ff [ENTRIES];

   logic                         hit_ff;
   logic [IDX_W-1:0]             hit_idx_ff;
   logic [IDX_W-1:0]             victim_idx_ff;
   logic                         victim_live_ff;
   logic                         scan_vld_ff;
   logic [IDX_W-1:0]             scan_idx_d_ff;
   logic [TIME_W-1:0]            best_time_ff;

   logic [VA_W-1:0]              page_full;
   logic [PAGE_W-1:0]            page_cur;
   logic [PAGE_BITS-1:0]         offset;
   logic [ENTRIES-1:0]           hit_vec;
   logic                         hit_any;
   logic [IDX_W-1:0]             hit_idx;
   logic                         free_any;
   logic [IDX_W-1:0]             free_idx;
   logic                         align_err;

   logic [ATTR_W-1:0]            attr_rd;
   logic [ATTR_W-1:0]            attr_wd;
   logic                         attr_we;
   logic [IDX_W-1:0]             attr_wa;
   logic [IDX_W-1:0]             attr_ra;
   logic [PAGE_W-1:0]            a_page;
   logic [FRAME_W-1:0]           a_frame;
   logic                         a_ro;
   logic                         a_dirty;
   logic                         a_used;

   logic                         last_we;
   logic [IDX_W-1:0]             last_wa;
   logic [TIME_W-1:0]            last_rd;
   logic [TIME_W-1:0]            ins_rd;
   logic [TIME_W-1:0]            scan_time;

   tlbtr_pkg::status_type        xl_status;
   logic                         xl_ok;
   logic [FRAME_W+PAGE_BITS-1:0] pa_full;

   assign page_full = va_ff >> PAGE_BITS;
   assign page_cur  = page_full[PAGE_W-1:0];
   assign offset    = va_ff[PAGE_BITS-1:0];

   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (page_ff[i] == page_cur);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign hit_any  = |hit_vec;
   assign free_any = ~&valid_ff;

   assign stat.op_refill = (req_opcode == tlbtr_pkg::OP_REFILL);
   assign stat.any_free  = free_any;

   assign align_err =
      ((size_ff >= tlbtr_pkg::SIZE_WORD) && ((va_ff & tlbtr_pkg::ALIGN_WORD_MASK) != '0)) ||
      ((size_ff == tlbtr_pkg::SIZE_HALF) && ((va_ff & tlbtr_pkg::ALIGN_HALF_MASK) != '0));

   assign {a_page, a_frame, a_ro, a_dirty, a_used} = attr_rd;
   assign pa_full = {a_frame, offset};

   always_comb begin
      if (align_err) begin
         xl_status = tlbtr_pkg::STAT_ALIGN;
      end else if (!hit_ff) begin
         xl_status = tlbtr_pkg::STAT_MISS;
      end else if (a_ro && wr_ff) begin
         xl_status = tlbtr_pkg::STAT_RDONLY;
      end else if ({1'b0, a_frame} >= (FRAME_W + 1)'(PHYS_PAGES)) begin
         xl_status = tlbtr_pkg::STAT_BUS;
      end else begin
         xl_status = tlbtr_pkg::STAT_OK;
      end
   end

   assign xl_ok = cmd.eval && (xl_status == tlbtr_pkg::STAT_OK);

   // attribute store: page copy, frame and flags
   assign attr_ra = cmd.victim_rd ? victim_idx_ff : hit_idx;
   assign attr_we = xl_ok || cmd.fill;
   assign attr_wa = cmd.fill ? victim_idx_ff : hit_idx_ff;
   assign attr_wd = cmd.fill ?
      {page_cur, fill_frame_ff, fill_ro_ff, fill_dirty_ff, fill_use_ff} :
      {a_page, a_frame, a_ro, a_dirty | wr_ff, 1'b1};

   assign last_we = xl_ok || cmd.fill;
   assign last_wa = cmd.fill ? victim_idx_ff : hit_idx_ff;

   tlbtr_ram #(.WIDTH(ATTR_W), .DEPTH(ENTRIES)) u_attr_ram (
      .clock   (clock),
      .wr_en   (attr_we),
      .wr_addr (attr_wa),
      .wr_data (attr_wd),
      .rd_addr (attr_ra),
      .rd_data (attr_rd)
   );

   tlbtr_ram #(.WIDTH(TIME_W), .DEPTH(ENTRIES)) u_last_ram (
      .clock   (clock),
      .wr_en   (last_we),
      .wr_addr (last_wa),
      .wr_data (time_ff),
      .rd_addr (scan_idx),
      .rd_data (last_rd)
   );

   tlbtr_ram #(.WIDTH(TIME_W), .DEPTH(ENTRIES)) u_ins_ram (
      .clock   (clock),
      .wr_en   (cmd.fill),
      .wr_addr (victim_idx_ff),
      .wr_data (time_ff),
      .rd_addr (scan_idx),
      .rd_data (ins_rd)
   );

   assign scan_time = mode_ff ? last_rd : ins_rd;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b1;
         valid_ff    <= '0;
         scan_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (cmd.fill) begin
            valid_ff[victim_idx_ff] <= 1'b1;
         end
         scan_vld_ff <= cmd.scan_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         va_ff         <= req_virt_addr;
         size_ff       <= req_size_code;
         wr_ff         <= req_is_write;
         time_ff       <= req_time_stamp;
         fill_frame_ff <= req_fill_frame;
         fill_ro_ff    <= req_fill_read_only;
         fill_dirty_ff <= req_fill_dirty;
         fill_use_ff   <= req_fill_use;
      end
      if (cmd.match) begin
         hit_ff     <= hit_any;
         hit_idx_ff <= hit_idx;
      end
      scan_idx_d_ff <= scan_idx;
      if (cmd.pick) begin
         victim_live_ff <= !free_any;
         if (free_any) begin
            victim_idx_ff <= free_idx;
         end
      end
      // keep the oldest stamp; ties stay with the lower index
      if (scan_vld_ff && ((scan_idx_d_ff == '0) || (scan_time < best_time_ff))) begin
         best_time_ff  <= scan_time;
         victim_idx_ff <= scan_idx_d_ff;
      end
      if (cmd.fill) begin
         page_ff[victim_idx_ff] <= page_cur;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         rsp_status           <= xl_status;
         rsp_phys_addr        <= xl_ok ? pa_full[PA_W-1:0] : '0;
         rsp_victim_valid     <= 1'b0;
         rsp_victim_page      <= '0;
         rsp_victim_frame     <= '0;
         rsp_victim_read_only <= 1'b0;
         rsp_victim_dirty     <= 1'b0;
         rsp_victim_use       <= 1'b0;
      end else if (cmd.fill) begin
         rsp_status           <= tlbtr_pkg::STAT_OK;
         rsp_phys_addr        <= '0;
         rsp_victim_valid     <= victim_live_ff;
         rsp_victim_page      <= victim_live_ff ? a_page : '0;
         rsp_victim_frame     <= victim_live_ff ? a_frame : '0;
         rsp_victim_read_only <= victim_live_ff && a_ro;
         rsp_victim_dirty     <= victim_live_ff && a_dirty;
         rsp_victim_use       <= victim_live_ff && a_used;
      end
   end

endmodule
